// ===== design/bdlp_pkg.sv =====
// bdlp_pkg: shared constants and types for the button debouncer with long-press detect.
// No dependencies; used by bdlp_btn and button_debounce_long_press.
`default_nettype none

package bdlp_pkg;

    localparam int NUM_BUTTONS = 2;
    localparam int TIME_W      = 32;
    localparam int POLLS_W     = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 1;

    // stream widths, rounded up to whole bytes
    localparam int IN_BITS     = NUM_BUTTONS + TIME_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = 3 * NUM_BUTTONS;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_POLLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MS  = 1'd1;

    // register reset values
    localparam logic [POLLS_W-1:0] DEBOUNCE_POLLS_RST = 8'd16;
    localparam logic [TIME_W-1:0]  LONG_PRESS_MS_RST  = 32'd2500;

    // per-button event pulses for one poll
    typedef struct packed {
        logic rise;
        logic fall;
        logic long_press;
    } t_btn_evt;

endpackage

`default_nettype wire

// ===== design/button_debounce_long_press.sv =====
// button_debounce_long_press: top level, stream ports, config registers, result register.
// Depends on bdlp_pkg and bdlp_btn.
//
//  Channel  | Direction | Handshake                   | Contents
//  s_axis   | in        | s_axis_tvalid/s_axis_tready | one poll: button levels, time in ms
//  m_axis   | out       | m_axis_tvalid/m_axis_tready | one event set per poll
//  cfg      | in        | i_cfg_we (no wait)          | debounce count, long-press time
//
// Each poll transfer produces exactly one result, registered in the cycle after acceptance.
// Throughput is one poll per clock while m_axis is not stalled: s_axis_tready is high
// whenever the result register is empty or is being drained in the same cycle.
// Synchronous active-low reset: registers go to 16 polls / 2500 ms, every button's fall
// edge is armed, counters and timestamps clear, and the result register empties.
// A stalled output holds its result; polls wait upstream until it is taken.
`default_nettype none

module button_debounce_long_press (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // poll input; tdata: levels[1:0], now_ms[33:2], zero pad up to bit 39
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [bdlp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // events; tdata: rise_events[1:0], fall_events[3:2], long_press_events[5:4], pad [7:6]
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [bdlp_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    // configuration writes
    input  wire logic                                 i_cfg_we,
    input  wire logic [bdlp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [bdlp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int NB = bdlp_pkg::NUM_BUTTONS;

    // configuration registers
    logic [bdlp_pkg::POLLS_W-1:0] r_debounce_polls;
    logic [bdlp_pkg::TIME_W-1:0]  r_long_press_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_polls <= bdlp_pkg::DEBOUNCE_POLLS_RST;
            r_long_press_ms  <= bdlp_pkg::LONG_PRESS_MS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bdlp_pkg::REG_DEBOUNCE_POLLS: begin
                    r_debounce_polls <= i_cfg_data[bdlp_pkg::POLLS_W-1:0];
                end
                bdlp_pkg::REG_LONG_PRESS_MS: begin
                    r_long_press_ms <= i_cfg_data[bdlp_pkg::TIME_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // input field unpacking
    logic [NB-1:0]               levels;
    logic [bdlp_pkg::TIME_W-1:0] now_ms;
    assign levels = s_axis_tdata[NB-1:0];
    assign now_ms = s_axis_tdata[NB +: bdlp_pkg::TIME_W];

    // output register: accept a new poll while the old result is drained
    logic r_out_valid;
    logic poll_xfer;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign poll_xfer     = s_axis_tvalid && s_axis_tready;

    // per-button update, one lane each
    logic [NB-1:0] rise_evt, fall_evt, lp_evt;

    for (genvar b = 0; b < NB; b++) begin : g_btn
        bdlp_pkg::t_btn_evt evt;

        bdlp_btn u_btn (
            .i_clk            (i_clk),
            .i_rst_n          (i_rst_n),
            .i_en             (poll_xfer),
            .i_level          (levels[b]),
            .i_now_ms         (now_ms),
            .i_debounce_polls (r_debounce_polls),
            .i_long_press_ms  (r_long_press_ms),
            .o_evt            (evt)
        );

        assign rise_evt[b] = evt.rise;
        assign fall_evt[b] = evt.fall;
        assign lp_evt[b]   = evt.long_press;
    end

    logic [bdlp_pkg::OUT_BITS-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (poll_xfer) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (poll_xfer) begin
            r_out_data <= {lp_evt, fall_evt, rise_evt};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(bdlp_pkg::OUT_TDATA_W - bdlp_pkg::OUT_BITS){1'b0}}, r_out_data};

endmodule

`default_nettype wire

// ===== design/bdlp_btn.sv =====
// bdlp_btn: per-button debounce counters, edge arming and long-press timer.
// Depends on bdlp_pkg.
`default_nettype none

module bdlp_btn (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_en,       // poll transfer accepted
    input  wire logic                             i_level,    // 1 released, 0 pressed
    input  wire logic [bdlp_pkg::TIME_W-1:0]      i_now_ms,
    input  wire logic [bdlp_pkg::POLLS_W-1:0]     i_debounce_polls,
    input  wire logic [bdlp_pkg::TIME_W-1:0]      i_long_press_ms,
    output bdlp_pkg::t_btn_evt                    o_evt
);

    logic [bdlp_pkg::POLLS_W-1:0] r_high_cnt, n_high_cnt;
    logic [bdlp_pkg::POLLS_W-1:0] r_low_cnt,  n_low_cnt;
    logic                         r_rise_arm, n_rise_arm;
    logic                         r_fall_arm, n_fall_arm;
    logic [bdlp_pkg::TIME_W-1:0]  r_last_high, n_last_high;

    logic [bdlp_pkg::POLLS_W-1:0] high_inc;
    logic [bdlp_pkg::POLLS_W-1:0] low_inc;
    logic [bdlp_pkg::TIME_W-1:0]  elapsed;

    assign high_inc = r_high_cnt + 1'b1;
    assign low_inc  = r_low_cnt + 1'b1;
    assign elapsed  = i_now_ms - r_last_high;   // wraps mod 2^32

    always_comb begin
        n_high_cnt  = r_high_cnt;
        n_low_cnt   = r_low_cnt;
        n_rise_arm  = r_rise_arm;
        n_fall_arm  = r_fall_arm;
        n_last_high = r_last_high;
        o_evt       = '0;
        if (i_level) begin
            n_low_cnt = '0;
            if (r_rise_arm) begin
                if (high_inc == i_debounce_polls) begin
                    n_high_cnt = '0;
                    o_evt.rise = 1'b1;
                    n_rise_arm = 1'b0;
                    n_fall_arm = 1'b1;
                end else begin
                    n_high_cnt = high_inc;
                end
            end
            n_last_high = i_now_ms;
        end else begin
            n_high_cnt = '0;
            if (r_fall_arm) begin
                if (low_inc == i_debounce_polls) begin
                    n_low_cnt  = '0;
                    o_evt.fall = 1'b1;
                    n_fall_arm = 1'b0;
                    n_rise_arm = 1'b1;
                end else begin
                    n_low_cnt = low_inc;
                end
            end
            // held low too long: pulse and re-arm the timer
            if (elapsed > i_long_press_ms) begin
                o_evt.long_press = 1'b1;
                n_last_high      = i_now_ms;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_cnt  <= '0;
            r_low_cnt   <= '0;
            r_rise_arm  <= 1'b0;
            r_fall_arm  <= 1'b1;
            r_last_high <= '0;
        end else if (i_en) begin
            r_high_cnt  <= n_high_cnt;
            r_low_cnt   <= n_low_cnt;
            r_rise_arm  <= n_rise_arm;
            r_fall_arm  <= n_fall_arm;
            r_last_high <= n_last_high;
        end
    end

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// tb_top: self-checking testbench for button_debounce_long_press.
// Depends on bdlp_pkg and the DUT; drives polls on s_axis, checks events on m_axis.
`timescale 1ns / 1ps

module tb_top;

    // per-poll event set, rise_events in the lowest bits as on m_axis_tdata
    typedef struct packed {
        logic [bdlp_pkg::NUM_BUTTONS-1:0] long_press;
        logic [bdlp_pkg::NUM_BUTTONS-1:0] fall;
        logic [bdlp_pkg::NUM_BUTTONS-1:0] rise;
    } t_event_set;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [bdlp_pkg::IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [bdlp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                              i_cfg_we = 1'b0;
    logic [bdlp_pkg::CFG_IDX_W-1:0]    i_cfg_idx = '0;
    logic [bdlp_pkg::CFG_DATA_W-1:0]   i_cfg_data = '0;

    button_debounce_long_press DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Debouncer model: its own copy of the registers and per-button state
    // ------------------------------------------------------------------
    logic [bdlp_pkg::POLLS_W-1:0] cfg_polls;
    logic [bdlp_pkg::TIME_W-1:0]  cfg_hold_ms;
    logic [7:0]                   high_cnt [bdlp_pkg::NUM_BUTTONS];
    logic [7:0]                   low_cnt [bdlp_pkg::NUM_BUTTONS];
    logic                         rise_arm [bdlp_pkg::NUM_BUTTONS];
    logic                         fall_arm [bdlp_pkg::NUM_BUTTONS];
    logic [bdlp_pkg::TIME_W-1:0]  seen_high_ms [bdlp_pkg::NUM_BUTTONS];

    t_event_set pending_events [$];   // events owed by the DUT, oldest first
    int         error_count = 0;
    bit         sender_idles = 1'b0;
    bit         receiver_stalls = 1'b0;
    logic [bdlp_pkg::TIME_W-1:0] clock_ms = '0;  // running time stamp for random polls

    // One poll through the debouncer model; updates the model state.
    function automatic t_event_set predict_buttons(logic [bdlp_pkg::NUM_BUTTONS-1:0] lv,
                                                   logic [bdlp_pkg::TIME_W-1:0] now);
        t_event_set ev;
        logic [bdlp_pkg::TIME_W-1:0] held_ms;
        ev = '0;
        for (int b = 0; b < bdlp_pkg::NUM_BUTTONS; b++) begin
            if (lv[b]) begin
                low_cnt[b] = 8'd0;
                if (rise_arm[b]) begin
                    high_cnt[b] = high_cnt[b] + 8'd1;   // wraps, so count 0 means 256 polls
                    if (high_cnt[b] == cfg_polls) begin
                        high_cnt[b] = 8'd0;
                        ev.rise[b]  = 1'b1;
                        rise_arm[b] = 1'b0;
                        fall_arm[b] = 1'b1;
                    end
                end
                seen_high_ms[b] = now;
            end else begin
                high_cnt[b] = 8'd0;
                if (fall_arm[b]) begin
                    low_cnt[b] = low_cnt[b] + 8'd1;
                    if (low_cnt[b] == cfg_polls) begin
                        low_cnt[b]  = 8'd0;
                        ev.fall[b]  = 1'b1;
                        fall_arm[b] = 1'b0;
                        rise_arm[b] = 1'b1;
                    end
                end
                // wrapping elapsed time; re-arm the stamp so the event repeats
                held_ms = now - seen_high_ms[b];
                if (held_ms > cfg_hold_ms) begin
                    ev.long_press[b] = 1'b1;
                    seen_high_ms[b]  = now;
                end
            end
        end
        return ev;
    endfunction

    // ------------------------------------------------------------------
    // Poll sender: optional idle burst, then hold tvalid until the transfer.
    // tvalid is left high afterwards so back-to-back polls never see a
    // low/high pair of assignments in one time step.
    // ------------------------------------------------------------------
    task automatic send_poll(input logic [bdlp_pkg::NUM_BUTTONS-1:0] lv,
                             input logic [bdlp_pkg::TIME_W-1:0] now);
        int gap;
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(bdlp_pkg::IN_TDATA_W - bdlp_pkg::IN_BITS){1'b0}}, now, lv};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_events.push_back(predict_buttons(lv, now));
    endtask

    // Stop sending and wait until every owed event set has been taken.
    task automatic wait_events_done();
        s_axis_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
    endtask

    // Register write; only called with nothing in flight.
    task automatic write_reg(input logic [bdlp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bdlp_pkg::CFG_DATA_W-1:0] val);
        wait_events_done();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == bdlp_pkg::REG_DEBOUNCE_POLLS)
            cfg_polls = val[bdlp_pkg::POLLS_W-1:0];
        else
            cfg_hold_ms = val[bdlp_pkg::TIME_W-1:0];
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall bursts on tready, checker on every transfer
    // ------------------------------------------------------------------
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (receiver_stalls && stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
            stall_left    <= $urandom_range(0, 9);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_event_set want;
        t_event_set got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[bdlp_pkg::OUT_BITS-1:0];
            if (pending_events.size() == 0) begin
                $error("unexpected event transfer, tdata=%h", m_axis_tdata);
                error_count++;
            end else begin
                want = pending_events.pop_front();
                if (got.rise !== want.rise) begin
                    $error("rise_events: expected %b, got %b", want.rise, got.rise);
                    error_count++;
                end
                if (got.fall !== want.fall) begin
                    $error("fall_events: expected %b, got %b", want.fall, got.fall);
                    error_count++;
                end
                if (got.long_press !== want.long_press) begin
                    $error("long_press_events: expected %b, got %b",
                           want.long_press, got.long_press);
                    error_count++;
                end
                if (m_axis_tdata[bdlp_pkg::OUT_TDATA_W-1:bdlp_pkg::OUT_BITS] !== '0) begin
                    $error("tdata pad: expected 0, got %b",
                           m_axis_tdata[bdlp_pkg::OUT_TDATA_W-1:bdlp_pkg::OUT_BITS]);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset defaults (16 polls, 2500 ms): a button held low since reset
    // long-presses once time passes 2500; an unarmed rise does nothing;
    // 16 low polls give the first fall.
    task automatic test_power_on();
        send_poll(2'b00, 32'd2500);            // equal to threshold: no event
        send_poll(2'b00, 32'd2501);            // just past it: both buttons fire
        send_poll(2'b11, 32'd7);               // rise not armed yet
        for (int n = 0; n < 16; n++)
            send_poll(2'b00, 32'd8 + n);
    endtask

    // Count of 1 so every level change is an edge; threshold at both ends;
    // time stamps at the ends of the range and across the wrap.
    task automatic test_edge_extremes();
        write_reg(bdlp_pkg::REG_DEBOUNCE_POLLS, 32'd1);
        write_reg(bdlp_pkg::REG_LONG_PRESS_MS, 32'hFFFF_FFFF);   // can never be exceeded
        send_poll(2'b11, 32'hFFFF_FFF0);
        send_poll(2'b00, 32'hFFFF_FFFF);
        send_poll(2'b01, 32'h0000_0000);
        send_poll(2'b10, 32'hFFFF_FFFE);
        write_reg(bdlp_pkg::REG_LONG_PRESS_MS, 32'd0);           // any nonzero elapsed time fires
        send_poll(2'b11, 32'hFFFF_FFF0);
        send_poll(2'b00, 32'hFFFF_FFF0);               // zero elapsed: no long press
        send_poll(2'b00, 32'h0000_0010);               // across the wrap
        send_poll(2'b00, 32'h0000_0010);
        write_reg(bdlp_pkg::REG_DEBOUNCE_POLLS, 32'd255);  // largest count, partial run only
        write_reg(bdlp_pkg::REG_LONG_PRESS_MS, 32'h8000_0000);
        send_poll(2'b11, 32'h1234_5678);
        send_poll(2'b01, 32'h9234_5679);               // button 1 past half the range
    endtask

    // Count of 0: the counter wraps, so an edge needs 256 equal polls.
    task automatic test_zero_count();
        write_reg(bdlp_pkg::REG_DEBOUNCE_POLLS, 32'd0);
        write_reg(bdlp_pkg::REG_LONG_PRESS_MS, 32'd100);
        for (int n = 0; n < 258; n++)
            send_poll(2'b10, 32'd1000 + n * 3);
    endtask

    // Press/release episodes with bounce noise and a wandering clock.
    task automatic test_random_press(input int polls, input int hold_ms, input int count,
                                     input bit idles);
        logic [bdlp_pkg::NUM_BUTTONS-1:0] target;
        logic [bdlp_pkg::NUM_BUTTONS-1:0] lv;
        int run_left [bdlp_pkg::NUM_BUTTONS];
        int span;
        int step_max;
        sender_idles    = idles;
        receiver_stalls = idles;
        write_reg(bdlp_pkg::REG_DEBOUNCE_POLLS, polls);
        write_reg(bdlp_pkg::REG_LONG_PRESS_MS, hold_ms);
        span     = (cfg_polls == 0) ? 256 : cfg_polls;
        step_max = hold_ms / 4 + 2;
        target   = bdlp_pkg::NUM_BUTTONS'($urandom_range(0, 3));
        for (int b = 0; b < bdlp_pkg::NUM_BUTTONS; b++)
            run_left[b] = 0;
        for (int n = 0; n < count; n++) begin
            for (int b = 0; b < bdlp_pkg::NUM_BUTTONS; b++) begin
                if (run_left[b] == 0) begin
                    if ($urandom_range(0, 3) != 0)
                        target[b] = ~target[b];
                    run_left[b] = $urandom_range(1, 2 * span + 2);
                end
                run_left[b]--;
            end
            lv = target;
            if ($urandom_range(0, 9) == 0)
                lv[$urandom_range(0, bdlp_pkg::NUM_BUTTONS - 1)] ^= 1'b1;   // contact bounce
            case ($urandom_range(0, 19))
                0:       clock_ms = $urandom();                   // time jump anywhere
                1:       clock_ms = clock_ms - $urandom_range(0, 50);
                default: clock_ms = clock_ms + $urandom_range(0, step_max);
            endcase
            send_poll(lv, clock_ms);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial begin
        // model state after reset
        cfg_polls   = bdlp_pkg::DEBOUNCE_POLLS_RST;
        cfg_hold_ms = bdlp_pkg::LONG_PRESS_MS_RST;
        for (int b = 0; b < bdlp_pkg::NUM_BUTTONS; b++) begin
            high_cnt[b]     = 8'd0;
            low_cnt[b]      = 8'd0;
            rise_arm[b]     = 1'b0;
            fall_arm[b]     = 1'b1;
            seen_high_ms[b] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        test_power_on();
        test_edge_extremes();
        test_zero_count();

        clock_ms = 32'hFFFF_F000;   // let the random clock cross the wrap early
        test_random_press(1, 0, 100, 1'b1);
        test_random_press(3, 20, 100, 1'b0);   // stretch without idling
        test_random_press($urandom_range(2, 6), $urandom_range(5, 60), 120, 1'b1);
        // last part runs with no idling on either side
        test_random_press(2, 10, 100, 1'b0);

        wait_events_done();
        repeat (5) @(posedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
design/bdlp_pkg.sv
design/bdlp_btn.sv
design/button_debounce_long_press.sv
test/tb_top.sv
